// File: design/nae_pkg.sv
// ---------------------------------------------------------------------------
// nae_pkg
// Shared types, codes and the tanh sample function of the NNUE evaluator.
// ---------------------------------------------------------------------------
package nae_pkg;

  // request codes
  localparam logic [2:0] REQ_LOAD   = 3'd0;
  localparam logic [2:0] REQ_ARST   = 3'd1;
  localparam logic [2:0] REQ_ADD    = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_EVAL   = 3'd4;

  // weight tables
  localparam logic [2:0] TBL_FEAT  = 3'd0;
  localparam logic [2:0] TBL_BIAS0 = 3'd1;
  localparam logic [2:0] TBL_L1W   = 3'd2;
  localparam logic [2:0] TBL_L1B   = 3'd3;
  localparam logic [2:0] TBL_L2W   = 3'd4;
  localparam logic [2:0] TBL_L2B   = 3'd5;
  localparam logic [2:0] TBL_L3W   = 3'd6;
  localparam logic [2:0] TBL_L3B   = 3'd7;

  // internal command codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ARST = 2'd1;
  localparam logic [1:0] OP_UPD  = 2'd2;
  localparam logic [1:0] OP_EVAL = 2'd3;

  localparam int          FEATURE_COUNT = 768;
  localparam logic [3:0]  PIECE_MAX     = 4'd11;
  localparam logic [3:0]  COLOR_SWAP    = 4'd6;
  localparam logic [5:0]  SQ_FLIP       = 6'd56;
  localparam logic [15:0] ACT_MAX       = 16'd32767;
  localparam int          FRAC_BITS     = 10;
  localparam int          TANH_SPAN_SH  = 12;
  localparam logic [10:0] TANH_ONE      = 11'd1024;

  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned EXP_NEG1_Q30 = 64'd395007542;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         piece;
    logic [5:0]         square;
    logic [2:0]         weight_table;
    logic [17:0]        weight_index;
    logic signed [15:0] weight_value;
    logic               side_to_move;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] score;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               remove;
    logic               black;
    logic [9:0]         wf;
    logic [9:0]         bf;
    logic [2:0]         tbl;
    logic [17:0]        widx;
    logic signed [15:0] wval;
  } cmd_t;

  // shift-and-subtract quotient, used only while building the tanh samples
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q, rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[62:0], a[bi]};
      if (rem >= b) begin
        rem   = rem - b;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q6.10 sample of tanh(4k/n), evaluated at elaboration
  function automatic logic [15:0] tanh_entry(input longint unsigned k,
                                             input longint unsigned n);
    longint unsigned y, ip, f, term, pos, neg, r, e, q;
    y  = udiv64((k * 64'd8) << 30, n);
    ip = y >> 30;
    f  = y & (Q30_ONE - 64'd1);
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = 64'd0;
    for (int t = 1; t <= 20; t++) begin
      term = udiv64((term * f) >> 30, 64'(t));
      if (t[0]) neg = neg + term;
      else pos = pos + term;
    end
    r = (pos >= neg) ? pos - neg : 64'd0;
    for (longint unsigned m = 0; m < ip; m++) r = (r * EXP_NEG1_Q30) >> 30;
    e = (r > Q30_ONE) ? Q30_ONE : r;
    q = udiv64(((Q30_ONE - e) << 10) + ((Q30_ONE + e) >> 1), Q30_ONE + e);
    return q[15:0];
  endfunction

endpackage

// File: design/nae_front.sv
// ---------------------------------------------------------------------------
// nae_front
// Accepts input transactions, drops the ones with no effect, maps features
// to table rows and queues commands for the back end in a two-entry FIFO.
// ---------------------------------------------------------------------------
module nae_front #(
  parameter int HIDDEN_WIDTH = 256,
  parameter int LAYER1_WIDTH = 32,
  parameter int LAYER2_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nae_pkg::in_item_t in_data,
  input  logic              clr_busy,
  output logic              q_valid,
  input  logic              q_pop,
  output nae_pkg::cmd_t     q_data
);

  localparam int FW_D  = nae_pkg::FEATURE_COUNT * HIDDEN_WIDTH;
  localparam int L1W_D = LAYER1_WIDTH * 2 * HIDDEN_WIDTH;
  localparam int L2W_D = LAYER2_WIDTH * LAYER1_WIDTH;
  localparam int L3W_D = LAYER2_WIDTH + 1;

  nae_pkg::cmd_t fifo_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;
  nae_pkg::cmd_t cmd;
  logic          keep;
  logic          push;
  logic [3:0]    swapped;
  logic [31:0]   idx32;

  assign idx32   = 32'(in_data.weight_index);
  assign swapped = (in_data.piece >= nae_pkg::COLOR_SWAP) ?
                   in_data.piece - nae_pkg::COLOR_SWAP : in_data.piece + nae_pkg::COLOR_SWAP;

  always_comb begin
    cmd.op     = nae_pkg::OP_LOAD;
    cmd.remove = (in_data.req_type == nae_pkg::REQ_REMOVE);
    cmd.black  = in_data.side_to_move;
    cmd.wf     = {in_data.piece, in_data.square ^ nae_pkg::SQ_FLIP};
    cmd.bf     = {swapped, in_data.square};
    cmd.tbl    = in_data.weight_table;
    cmd.widx   = in_data.weight_index;
    cmd.wval   = in_data.weight_value;
    keep       = 1'b0;
    case (in_data.req_type)
      nae_pkg::REQ_LOAD: begin
        cmd.op = nae_pkg::OP_LOAD;
        case (in_data.weight_table)
          nae_pkg::TBL_FEAT:  keep = idx32 < 32'(FW_D);
          nae_pkg::TBL_BIAS0: keep = idx32 < 32'(HIDDEN_WIDTH);
          nae_pkg::TBL_L1W:   keep = idx32 < 32'(L1W_D);
          nae_pkg::TBL_L1B:   keep = idx32 < 32'(LAYER1_WIDTH);
          nae_pkg::TBL_L2W:   keep = idx32 < 32'(L2W_D);
          nae_pkg::TBL_L2B:   keep = idx32 < 32'(LAYER2_WIDTH);
          nae_pkg::TBL_L3W:   keep = idx32 < 32'(L3W_D);
          default: begin
            // output bias lives after the last layer-3 weight
            keep     = (idx32 == 32'd0);
            cmd.tbl  = nae_pkg::TBL_L3W;
            cmd.widx = 18'(LAYER2_WIDTH);
          end
        endcase
      end
      nae_pkg::REQ_ARST: begin
        cmd.op = nae_pkg::OP_ARST;
        keep   = 1'b1;
      end
      nae_pkg::REQ_ADD, nae_pkg::REQ_REMOVE: begin
        cmd.op = nae_pkg::OP_UPD;
        keep   = (in_data.piece <= nae_pkg::PIECE_MAX);
      end
      nae_pkg::REQ_EVAL: begin
        cmd.op = nae_pkg::OP_EVAL;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !clr_busy && (count_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/nae_back.sv
// ---------------------------------------------------------------------------
// nae_back
// Executes queued commands: weight loads, accumulator reset and feature
// update sweeps, and the dense layers through one shared MAC pipeline,
// then tanh lookup, scaling and the result register.
// ---------------------------------------------------------------------------
module nae_back #(
  parameter int HIDDEN_WIDTH = 256,
  parameter int LAYER1_WIDTH = 32,
  parameter int LAYER2_WIDTH = 32,
  parameter int TANH_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  nae_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               clr_busy,
  input  logic [9:0]         score_scale,
  output logic               out_valid,
  input  logic               out_ready,
  output nae_pkg::out_item_t out_data
);

  localparam int HW    = HIDDEN_WIDTH;
  localparam int HAW   = $clog2(HW);
  localparam int FW_D  = nae_pkg::FEATURE_COUNT * HW;
  localparam int FAW   = $clog2(FW_D);
  localparam int L1W_D = LAYER1_WIDTH * 2 * HW;
  localparam int L1AW  = $clog2(L1W_D);
  localparam int L2W_D = LAYER2_WIDTH * LAYER1_WIDTH;
  localparam int L2AW  = $clog2(L2W_D);
  localparam int L3W_D = LAYER2_WIDTH + 1;
  localparam int L3AW  = $clog2(L3W_D);
  localparam int O1AW  = $clog2(LAYER1_WIDTH);
  localparam int O2AW  = $clog2(LAYER2_WIDTH);
  localparam int OW    = (O1AW > O2AW) ? O1AW : O2AW;
  localparam int WA_W  = (L1AW > L2AW) ? L1AW : L2AW;
  localparam int NMAX0 = (2 * HW > LAYER1_WIDTH) ? 2 * HW : LAYER1_WIDTH;
  localparam int NMAX  = (NMAX0 > LAYER2_WIDTH) ? NMAX0 : LAYER2_WIDTH;
  localparam int SUM_W = 34 + $clog2(NMAX);
  localparam int TAW   = $clog2(TANH_ENTRIES);
  localparam int TPW   = 32 + $clog2(TANH_ENTRIES + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_ARST  = 4'd3;
  localparam logic [3:0] S_L1    = 4'd4;
  localparam logic [3:0] S_L2    = 4'd5;
  localparam logic [3:0] S_L3    = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_T1    = 4'd8;
  localparam logic [3:0] S_T2    = 4'd9;
  localparam logic [3:0] S_T3    = 4'd10;
  localparam logic [3:0] S_T4    = 4'd11;

  localparam logic [1:0] LAY_H1  = 2'd1;
  localparam logic [1:0] LAY_H2  = 2'd2;
  localparam logic [1:0] LAY_OUT = 2'd3;

  localparam logic signed [33:0] ACC_MAX = 34'sd2147483647;
  localparam logic signed [33:0] ACC_MIN = -34'sd2147483648;
  localparam logic signed [SUM_W-1:0] FIN_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] FIN_MIN = SUM_W'(-64'sd2147483648);

  // memories
  logic signed [15:0] fw_mem    [FW_D];
  logic signed [15:0] bias0_mem [HW];
  logic signed [15:0] l1w_mem   [L1W_D];
  logic signed [15:0] l1b_mem   [LAYER1_WIDTH];
  logic signed [15:0] l2w_mem   [L2W_D];
  logic signed [15:0] l2b_mem   [LAYER2_WIDTH];
  logic signed [15:0] l3w_mem   [L3W_D];
  logic signed [31:0] wacc_mem  [HW];
  logic signed [31:0] bacc_mem  [HW];
  logic [15:0]        act1_mem  [LAYER1_WIDTH];
  logic [15:0]        act2_mem  [LAYER2_WIDTH];
  logic [15:0]        tanh_rom  [TANH_ENTRIES];

  logic signed [15:0] fw_q0, fw_q1, bias0_q, l1w_q, l1b_q, l2w_q, l2b_q, l3w_q, l3b_q;
  logic signed [31:0] wacc_q, bacc_q;
  logic [15:0]        act1_q, act2_q, rom_q_r;

  // control
  logic [3:0]      state_r, drain_to_r;
  logic [HAW-1:0]  i_r, i1_r;
  logic            half_r;
  logic [OW-1:0]   o_r, j_r;
  logic [WA_W-1:0] waddr_r;
  logic            v1_r, v2_r, v3_r, u1_r, a1_r;
  logic            accum_clip_r, eval_clip_r, out_valid_r;
  logic            black_r, remove_r;
  logic [FAW-1:0]  wbase_r, bbase_r;
  nae_pkg::out_item_t out_data_r;

  // MAC pipeline
  logic            iss_v, iss_first, iss_last;
  logic [1:0]      iss_layer;
  logic            first1_r, last1_r, half1_r;
  logic [1:0]      layer1_r, layer2_r, layer3_r;
  logic [OW-1:0]   o1_r, o2_r, o3_r;
  logic            first2_r, last2_r;
  logic signed [15:0] bias2_r, bias3_r;
  logic signed [32:0] prod_r;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [31:0] out_r;

  // tanh path
  logic [TPW-1:0]  tp_r, tidx;
  logic            over_r;
  logic [20:0]     sc_r;
  logic [31:0]     mag32;
  logic [10:0]     tval, mag11;
  logic            neg_res;

  logic            busy;
  logic            ld_we;

  // ---------------- tanh samples
  for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_rom
    localparam logic [15:0] TV = nae_pkg::tanh_entry(64'(g), 64'(TANH_ENTRIES));
    assign tanh_rom[g] = TV;
  end

  assign ld_we = q_pop && (q_data.op == nae_pkg::OP_LOAD);

  // ---------------- memory ports
  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_FEAT) fw_mem[FAW'(q_data.widx)] <= q_data.wval;
    fw_q0 <= fw_mem[wbase_r + FAW'(i_r)];
    fw_q1 <= fw_mem[bbase_r + FAW'(i_r)];
  end

  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_BIAS0) bias0_mem[HAW'(q_data.widx)] <= q_data.wval;
    bias0_q <= bias0_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_L1W) l1w_mem[L1AW'(q_data.widx)] <= q_data.wval;
    l1w_q <= l1w_mem[L1AW'(waddr_r)];
  end

  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_L1B) l1b_mem[O1AW'(q_data.widx)] <= q_data.wval;
    l1b_q <= l1b_mem[O1AW'(o_r)];
  end

  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_L2W) l2w_mem[L2AW'(q_data.widx)] <= q_data.wval;
    l2w_q <= l2w_mem[L2AW'(waddr_r)];
  end

  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_L2B) l2b_mem[O2AW'(q_data.widx)] <= q_data.wval;
    l2b_q <= l2b_mem[O2AW'(o_r)];
  end

  always_ff @(posedge clk) begin
    if (ld_we && q_data.tbl == nae_pkg::TBL_L3W) l3w_mem[L3AW'(q_data.widx)] <= q_data.wval;
    l3w_q <= l3w_mem[L3AW'(j_r)];
    l3b_q <= l3w_mem[L3AW'(LAYER2_WIDTH)];
  end

  // ---------------- accumulator update
  logic               acc_we;
  logic [HAW-1:0]     acc_wa;
  logic signed [31:0] wacc_wd, bacc_wd;
  logic signed [16:0] dw, db;
  logic signed [33:0] wsum, bsum;
  logic               wclip, bclip;

  always_comb begin
    dw = remove_r ? -17'(fw_q0) : 17'(fw_q0);
    db = remove_r ? -17'(fw_q1) : 17'(fw_q1);
    wsum = 34'(wacc_q) + 34'(dw);
    bsum = 34'(bacc_q) + 34'(db);
    wclip = (wsum > ACC_MAX) || (wsum < ACC_MIN);
    bclip = (bsum > ACC_MAX) || (bsum < ACC_MIN);
    acc_we = (state_r == S_CLR) || u1_r || a1_r;
    acc_wa = (state_r == S_CLR) ? i_r : i1_r;
    if (state_r == S_CLR) begin
      wacc_wd = '0;
      bacc_wd = '0;
    end else if (a1_r) begin
      wacc_wd = 32'(bias0_q);
      bacc_wd = 32'(bias0_q);
    end else begin
      wacc_wd = (wsum > ACC_MAX) ? 32'sh7FFFFFFF :
                (wsum < ACC_MIN) ? 32'sh80000000 : 32'(wsum);
      bacc_wd = (bsum > ACC_MAX) ? 32'sh7FFFFFFF :
                (bsum < ACC_MIN) ? 32'sh80000000 : 32'(bsum);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) wacc_mem[acc_wa] <= wacc_wd;
    wacc_q <= wacc_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (acc_we) bacc_mem[acc_wa] <= bacc_wd;
    bacc_q <= bacc_mem[i_r];
  end

  // ---------------- issue
  always_comb begin
    iss_v     = 1'b0;
    iss_first = 1'b0;
    iss_last  = 1'b0;
    iss_layer = LAY_H1;
    case (state_r)
      S_L1: begin
        iss_v     = 1'b1;
        iss_first = (i_r == '0) && !half_r;
        iss_last  = (i_r == HAW'(HW - 1)) && half_r;
        iss_layer = LAY_H1;
      end
      S_L2: begin
        iss_v     = 1'b1;
        iss_first = (j_r == '0);
        iss_last  = (j_r == OW'(LAYER1_WIDTH - 1));
        iss_layer = LAY_H2;
      end
      S_L3: begin
        iss_v     = 1'b1;
        iss_first = (j_r == '0);
        iss_last  = (j_r == OW'(LAYER2_WIDTH - 1));
        iss_layer = LAY_OUT;
      end
      default: iss_v = 1'b0;
    endcase
  end

  // ---------------- stage 1: operand select
  logic signed [31:0] acc_word;
  logic [15:0]        act_op;
  logic               act0_clip;
  logic signed [15:0] w_op, b_op;

  always_comb begin
    acc_word  = (half1_r ^ black_r) ? bacc_q : wacc_q;
    act0_clip = 1'b0;
    case (layer1_r)
      LAY_H1: begin
        w_op = l1w_q;
        b_op = l1b_q;
        if (acc_word[31]) act_op = '0;
        else if (acc_word > 32'(nae_pkg::ACT_MAX)) begin
          act_op    = nae_pkg::ACT_MAX;
          act0_clip = 1'b1;
        end else act_op = acc_word[15:0];
      end
      LAY_H2: begin
        w_op   = l2w_q;
        b_op   = l2b_q;
        act_op = act1_q;
      end
      default: begin
        w_op   = l3w_q;
        b_op   = l3b_q;
        act_op = act2_q;
      end
    endcase
  end

  // ---------------- stage 3: finish sum
  logic signed [SUM_W-1:0] fin_tot, fin_fl;
  logic signed [31:0]      fin32;
  logic                    fin_sat, fin_aclip, fin_clip;
  logic [15:0]             fin_act;

  always_comb begin
    fin_tot = acc_r + (SUM_W'(bias3_r) <<< nae_pkg::FRAC_BITS);
    fin_fl  = fin_tot >>> nae_pkg::FRAC_BITS;
    fin_sat = 1'b1;
    if (fin_fl > FIN_MAX) fin32 = 32'sh7FFFFFFF;
    else if (fin_fl < FIN_MIN) fin32 = 32'sh80000000;
    else begin
      fin32   = 32'(fin_fl);
      fin_sat = 1'b0;
    end
    fin_aclip = 1'b0;
    if (fin32[31]) fin_act = '0;
    else if (fin32 > 32'(nae_pkg::ACT_MAX)) begin
      fin_act   = nae_pkg::ACT_MAX;
      fin_aclip = 1'b1;
    end else fin_act = fin32[15:0];
    fin_clip = fin_sat || (fin_aclip && layer3_r != LAY_OUT);
  end

  always_ff @(posedge clk) begin
    if (v3_r && layer3_r == LAY_H1) act1_mem[O1AW'(o3_r)] <= fin_act;
    act1_q <= act1_mem[O1AW'(j_r)];
  end

  always_ff @(posedge clk) begin
    if (v3_r && layer3_r == LAY_H2) act2_mem[O2AW'(o3_r)] <= fin_act;
    act2_q <= act2_mem[O2AW'(j_r)];
  end

  // ---------------- tanh and scale
  assign mag32   = out_r[31] ? 32'(-out_r) : 32'(out_r);
  assign tidx    = tp_r >> nae_pkg::TANH_SPAN_SH;
  assign tval    = over_r ? nae_pkg::TANH_ONE : rom_q_r[10:0];
  assign mag11   = sc_r[20:10];
  assign neg_res = out_r[31] ^ black_r;

  always_ff @(posedge clk) begin
    rom_q_r <= tanh_rom[TAW'(tidx)];
  end

  // ---------------- datapath registers
  always_ff @(posedge clk) begin
    first1_r <= iss_first;
    last1_r  <= iss_last;
    layer1_r <= iss_layer;
    o1_r     <= o_r;
    half1_r  <= half_r;
    i1_r     <= i_r;
    prod_r   <= 33'(w_op) * 33'($signed({1'b0, act_op}));
    first2_r <= first1_r;
    last2_r  <= last1_r;
    layer2_r <= layer1_r;
    o2_r     <= o1_r;
    bias2_r  <= b_op;
    if (v2_r) acc_r <= first2_r ? SUM_W'(prod_r) : acc_r + SUM_W'(prod_r);
    layer3_r <= layer2_r;
    o3_r     <= o2_r;
    bias3_r  <= bias2_r;
    if (v3_r && layer3_r == LAY_OUT) out_r <= fin32;
    if (q_pop) begin
      black_r  <= q_data.black;
      remove_r <= q_data.remove;
      wbase_r  <= FAW'(32'(q_data.wf) * 32'(HW));
      bbase_r  <= FAW'(32'(q_data.bf) * 32'(HW));
    end
    tp_r   <= TPW'(mag32) * TPW'(TANH_ENTRIES);
    over_r <= (tidx >= TPW'(TANH_ENTRIES));
    sc_r   <= 21'(tval) * 21'(score_scale);
    if (state_r == S_T4) begin
      out_data_r.score     <= neg_res ? -$signed(mag11) : $signed(mag11);
      out_data_r.saturated <= accum_clip_r || eval_clip_r;
    end
  end

  // ---------------- control
  assign busy     = v1_r || v2_r || v3_r || u1_r || a1_r;
  assign q_pop    = (state_r == S_IDLE) && q_valid &&
                    ((q_data.op != nae_pkg::OP_EVAL) || !out_valid_r);
  assign clr_busy = (state_r == S_CLR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      drain_to_r   <= S_IDLE;
      i_r          <= '0;
      half_r       <= 1'b0;
      o_r          <= '0;
      j_r          <= '0;
      waddr_r      <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      u1_r         <= 1'b0;
      a1_r         <= 1'b0;
      accum_clip_r <= 1'b0;
      eval_clip_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      v1_r <= iss_v;
      v2_r <= v1_r;
      v3_r <= v2_r && last2_r;
      u1_r <= (state_r == S_UPD);
      a1_r <= (state_r == S_ARST);
      if (u1_r && (wclip || bclip)) accum_clip_r <= 1'b1;
      if (v1_r && layer1_r == LAY_H1 && act0_clip) eval_clip_r <= 1'b1;
      if (v3_r && fin_clip) eval_clip_r <= 1'b1;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_CLR: begin
          i_r <= i_r + 1'b1;
          if (i_r == HAW'(HW - 1)) begin
            i_r     <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            i_r     <= '0;
            half_r  <= 1'b0;
            o_r     <= '0;
            j_r     <= '0;
            waddr_r <= '0;
            case (q_data.op)
              nae_pkg::OP_ARST: begin
                accum_clip_r <= 1'b0;
                state_r      <= S_ARST;
              end
              nae_pkg::OP_UPD:  state_r <= S_UPD;
              nae_pkg::OP_EVAL: begin
                eval_clip_r <= 1'b0;
                state_r     <= S_L1;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_UPD, S_ARST: begin
          i_r <= i_r + 1'b1;
          if (i_r == HAW'(HW - 1)) begin
            i_r        <= '0;
            drain_to_r <= S_IDLE;
            state_r    <= S_DRAIN;
          end
        end
        S_L1: begin
          waddr_r <= waddr_r + 1'b1;
          i_r     <= i_r + 1'b1;
          if (i_r == HAW'(HW - 1)) begin
            i_r    <= '0;
            half_r <= ~half_r;
            if (half_r) begin
              o_r <= o_r + 1'b1;
              if (o_r == OW'(LAYER1_WIDTH - 1)) begin
                drain_to_r <= S_L2;
                state_r    <= S_DRAIN;
              end
            end
          end
        end
        S_L2: begin
          waddr_r <= waddr_r + 1'b1;
          j_r     <= j_r + 1'b1;
          if (j_r == OW'(LAYER1_WIDTH - 1)) begin
            j_r <= '0;
            o_r <= o_r + 1'b1;
            if (o_r == OW'(LAYER2_WIDTH - 1)) begin
              drain_to_r <= S_L3;
              state_r    <= S_DRAIN;
            end
          end
        end
        S_L3: begin
          j_r <= j_r + 1'b1;
          if (j_r == OW'(LAYER2_WIDTH - 1)) begin
            drain_to_r <= S_T1;
            state_r    <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // next layer reads what the previous one wrote
          if (!busy) begin
            state_r <= drain_to_r;
            i_r     <= '0;
            half_r  <= 1'b0;
            o_r     <= '0;
            j_r     <= '0;
            waddr_r <= '0;
          end
        end
        S_T1: state_r <= S_T2;
        S_T2: state_r <= S_T3;
        S_T3: state_r <= S_T4;
        S_T4: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/nnue_accumulator_and_eval_top.sv
// ---------------------------------------------------------------------------
// nnue_accumulator_and_eval_top
// Chess NNUE evaluator: front end classifies transactions into a command
// queue, back end runs table loads, accumulator sweeps and the dense layers.
// ---------------------------------------------------------------------------
// Accumulator reset or feature add/remove sweeps the hidden words, one hidden
//   word per cycle through the accumulator RAM ports.
// Evaluate: one MAC per cycle in the shared MAC pipeline within each layer,
//   with a drain between layers before the next layer starts.
// After reset a clearing pass zeroes both accumulators; in_ready stays low
//   meanwhile. score_scale resets to 200.
module nnue_accumulator_and_eval_top #(
  parameter int HIDDEN_WIDTH = 256,
  parameter int LAYER1_WIDTH = 32,
  parameter int LAYER2_WIDTH = 32,
  parameter int TANH_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nae_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nae_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata
);

  logic [9:0]    score_scale_r;
  logic          clr_busy;
  logic          q_valid;
  logic          q_pop;
  nae_pkg::cmd_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) score_scale_r <= 10'd200;
    else if (cfg_we) score_scale_r <= cfg_wdata;
  end

  nae_front #(
    .HIDDEN_WIDTH(HIDDEN_WIDTH),
    .LAYER1_WIDTH(LAYER1_WIDTH),
    .LAYER2_WIDTH(LAYER2_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .clr_busy (clr_busy),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  nae_back #(
    .HIDDEN_WIDTH(HIDDEN_WIDTH),
    .LAYER1_WIDTH(LAYER1_WIDTH),
    .LAYER2_WIDTH(LAYER2_WIDTH),
    .TANH_ENTRIES(TANH_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .clr_busy    (clr_busy),
    .score_scale (score_scale_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // no transaction taken while accumulators are being cleared
  a_clr_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("input accepted during clearing pass");

  // an evaluate never starts while a result is still waiting
  a_eval_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.op == nae_pkg::OP_EVAL) |-> !out_valid)
    else $error("evaluate started with result slot full");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

endmodule
